// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros for the allow-list core; all reference clk/rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold on every clock outside reset
`define CPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define CPA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CPA_ASSERT(lbl, prop, msg)
`define CPA_NEVER(lbl, expr, msg)
`endif

`endif

// File: rtl/core/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared constants, types and mask helpers for the CIDR allow-list core.
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int V4_ENTRIES_DEF = 16;
    localparam int V6_ENTRIES_DEF = 16;

    localparam int V4_BITS = 32;
    localparam int V6_BITS = 128;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic do_insert;
        logic scan_step;
        logic load_result;
    } cpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic match_found;
        logic out_free;
    } cpa_sts_t;

    // network mask for an IPv4 prefix, p in 0..32
    function automatic logic [31:0] mask_v4(input logic [5:0] p);
        logic [31:0] m;
        for (int i = 0; i < 32; i++)
        begin
            m[i] = ((7'(i) + {1'b0, p}) >= 7'd32);
        end
        return m;
    endfunction

    // network mask for an IPv6 prefix, p in 0..128
    function automatic logic [127:0] mask_v6(input logic [7:0] p);
        logic [127:0] m;
        for (int i = 0; i < 128; i++)
        begin
            m[i] = ((9'(i) + {1'b0, p}) >= 9'd128);
        end
        return m;
    endfunction

endpackage

// File: rtl/core/cpa_req_if.sv
// ----------------------------------------------------------------------------
// cpa_req_if
// Request channel: insert or query transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        is_v6;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [7:0]  plen;

    modport source (
        output valid, cmd, is_v6, address_high, address_low, plen,
        input  ready
    );
    modport sink (
        input  valid, cmd, is_v6, address_high, address_low, plen,
        output ready
    );
endinterface

// File: rtl/core/cpa_rsp_if.sv
// ----------------------------------------------------------------------------
// cpa_rsp_if
// Response channel: one result transaction per request.
// ----------------------------------------------------------------------------
interface cpa_rsp_if;
    logic       valid;
    logic       ready;
    logic       allowed;
    logic [1:0] status;

    modport source (
        output valid, allowed, status,
        input  ready
    );
    modport sink (
        input  valid, allowed, status,
        output ready
    );
endinterface

// File: rtl/core/cpa_ctrl.sv
// ----------------------------------------------------------------------------
// cpa_ctrl
// Sequencer: accept, insert or scan the prefix table, hand off the result.
// ----------------------------------------------------------------------------
module cpa_ctrl
    import cpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_is_query,
    output logic     in_ready,
    output cpa_cmd_t cmd,
    input  cpa_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_RESPOND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = in_is_query ? S_SCAN : S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.do_insert = 1'b1;
                state_next    = S_RESPOND;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done || sts.match_found)
                begin
                    state_next = S_RESPOND;
                end
            end
            S_RESPOND:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

// File: rtl/core/cpa_datapath.sv
// ----------------------------------------------------------------------------
// cpa_datapath
// Item latch, prefix tables, scan compare and result register.
// ----------------------------------------------------------------------------
module cpa_datapath
    import cpa_pkg::*;
#(
    parameter int V4_ENTRIES = V4_ENTRIES_DEF,
    parameter int V6_ENTRIES = V6_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cpa_cmd_t    cmd,
    output cpa_sts_t    sts,
    input  logic        in_cmd,
    input  logic        in_is_v6,
    input  logic [63:0] in_address_high,
    input  logic [63:0] in_address_low,
    input  logic [7:0]  in_plen,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_allowed,
    output logic [1:0]  out_status
);

    localparam int C4W = $clog2(V4_ENTRIES + 1);
    localparam int C6W = $clog2(V6_ENTRIES + 1);
    localparam int A4W = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
    localparam int A6W = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
    localparam int SW  = (C4W > C6W) ? C4W : C6W;

    // latched transaction
    logic        item_cmd_reg;
    logic        item_v6_reg;
    logic [63:0] addr_hi_reg;
    logic [63:0] addr_lo_reg;
    logic [7:0]  plen_reg;

    logic [C4W-1:0] v4_count_reg;
    logic [C6W-1:0] v6_count_reg;
    logic [1:0]     ins_status_reg;

    // tables
    logic [31:0]  v4_net_mem [V4_ENTRIES];
    logic [5:0]   v4_pfx_mem [V4_ENTRIES];
    logic [127:0] v6_net_mem [V6_ENTRIES];
    logic [7:0]   v6_pfx_mem [V6_ENTRIES];

    logic [31:0]  v4_net_rd_reg;
    logic [5:0]   v4_pfx_rd_reg;
    logic [127:0] v6_net_rd_reg;
    logic [7:0]   v6_pfx_rd_reg;

    // scan
    logic [SW-1:0] rd_idx_reg;
    logic          cmp_valid_reg;
    logic          match_reg;
    logic [SW-1:0] own_count;
    logic          issue;
    logic          hit;

    // result
    logic       out_valid_reg;
    logic       out_allowed_reg;
    logic [1:0] out_status_reg;

    // insert decode
    logic       plen_bad;
    logic       v4_full;
    logic       v6_full;
    logic       tbl_full;
    logic       wr_v4;
    logic       wr_v6;
    logic [1:0] ins_status;

    assign v4_full  = (v4_count_reg == C4W'(V4_ENTRIES));
    assign v6_full  = (v6_count_reg == C6W'(V6_ENTRIES));
    assign plen_bad = item_v6_reg ? (plen_reg > 8'd128) : (plen_reg > 8'd32);
    assign tbl_full = item_v6_reg ? v6_full : v4_full;
    assign wr_v4    = cmd.do_insert && !item_v6_reg && !plen_bad && !v4_full;
    assign wr_v6    = cmd.do_insert && item_v6_reg && !plen_bad && !v6_full;

    always_comb
    begin
        if (plen_bad)
        begin
            ins_status = ST_BAD_PREFIX;
        end
        else if (tbl_full)
        begin
            ins_status = ST_FULL;
        end
        else
        begin
            ins_status = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_cmd_reg <= in_cmd;
            item_v6_reg  <= in_is_v6;
            addr_hi_reg  <= in_address_high;
            addr_lo_reg  <= in_address_low;
            plen_reg     <= in_plen;
        end
        if (cmd.do_insert)
        begin
            ins_status_reg <= ins_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_count_reg <= '0;
            v6_count_reg <= '0;
        end
        else
        begin
            if (wr_v4)
            begin
                v4_count_reg <= v4_count_reg + 1'b1;
            end
            if (wr_v6)
            begin
                v6_count_reg <= v6_count_reg + 1'b1;
            end
        end
    end

    // v4 table: write at fill count, registered read at scan index
    always_ff @(posedge clk)
    begin
        if (wr_v4)
        begin
            v4_net_mem[v4_count_reg[A4W-1:0]] <= addr_lo_reg[31:0] & mask_v4(plen_reg[5:0]);
            v4_pfx_mem[v4_count_reg[A4W-1:0]] <= plen_reg[5:0];
        end
        v4_net_rd_reg <= v4_net_mem[rd_idx_reg[A4W-1:0]];
        v4_pfx_rd_reg <= v4_pfx_mem[rd_idx_reg[A4W-1:0]];
    end

    // v6 table
    always_ff @(posedge clk)
    begin
        if (wr_v6)
        begin
            v6_net_mem[v6_count_reg[A6W-1:0]] <= {addr_hi_reg, addr_lo_reg} & mask_v6(plen_reg);
            v6_pfx_mem[v6_count_reg[A6W-1:0]] <= plen_reg;
        end
        v6_net_rd_reg <= v6_net_mem[rd_idx_reg[A6W-1:0]];
        v6_pfx_rd_reg <= v6_pfx_mem[rd_idx_reg[A6W-1:0]];
    end

    assign own_count = item_v6_reg ? SW'(v6_count_reg) : SW'(v4_count_reg);
    assign issue     = cmd.scan_step && (rd_idx_reg < own_count);

    always_comb
    begin
        if (item_v6_reg)
        begin
            hit = (({addr_hi_reg, addr_lo_reg} & mask_v6(v6_pfx_rd_reg)) == v6_net_rd_reg);
        end
        else
        begin
            hit = ((addr_lo_reg[31:0] & mask_v4(v4_pfx_rd_reg)) == v4_net_rd_reg);
        end
    end

    // one read issued per cycle, compared the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            cmp_valid_reg <= issue;
            if (cmp_valid_reg && hit)
            begin
                match_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            if (item_cmd_reg == CMD_QUERY)
            begin
                out_allowed_reg <= ((v4_count_reg == '0) && (v6_count_reg == '0)) || match_reg;
                out_status_reg  <= ST_OK;
            end
            else
            begin
                out_allowed_reg <= 1'b0;
                out_status_reg  <= ins_status_reg;
            end
        end
    end

    assign sts.scan_done   = (rd_idx_reg >= own_count) && !cmp_valid_reg;
    assign sts.match_found = match_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_allowed = out_allowed_reg;
    assign out_status  = out_status_reg;

endmodule

// File: rtl/core/cidr_prefix_allowlist_core.sv
// One transaction at a time; the table scan reads and compares one stored entry
// per cycle.
// Reset: rst_n asynchronous, active low; clears both fill counts (tables read empty).
// Table contents are not cleared; entries past the fill count are never used.
// ----------------------------------------------------------------------------
// cidr_prefix_allowlist_core
// IPv4/IPv6 CIDR allow-list: prefix insert and address lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cidr_prefix_allowlist_core
    import cpa_pkg::*;
#(
    parameter int V4_ENTRIES = V4_ENTRIES_DEF,
    parameter int V6_ENTRIES = V6_ENTRIES_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    cpa_req_if.sink      req,
    cpa_rsp_if.source    rsp
);

    // command/status bus between sequencer and datapath
    cpa_cmd_t cmd;
    cpa_sts_t sts;

    // Sequencer. Takes a transaction only in its idle state; the result
    // register in the datapath lets a new request in while the previous
    // result is still waiting on the response channel.
    cpa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_is_query (req.cmd == CMD_QUERY),
        .in_ready    (req.ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    // Datapath. Inserts store the masked network at the fill count of the
    // family's table. Queries walk the table from entry 0 with a registered
    // read; the compare runs in the cycle after the read and the scan stops
    // on the first match or at the fill count. With both tables empty every
    // query is allowed.
    cpa_datapath #(
        .V4_ENTRIES (V4_ENTRIES),
        .V6_ENTRIES (V6_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_cmd           (req.cmd),
        .in_is_v6         (req.is_v6),
        .in_address_high  (req.address_high),
        .in_address_low   (req.address_low),
        .in_plen          (req.plen),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_allowed      (rsp.allowed),
        .out_status       (rsp.status)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // only one transaction in flight: ready drops right after an accept
    `CPA_ASSERT(a_one_in_flight, (req.valid && req.ready) |=> !req.ready, "accept while busy")
    // a result is never loaded over one not yet taken
    `CPA_NEVER(a_no_overwrite, cmd.load_result && !sts.out_free, "result overwritten")
    // response valid rises only from a result load
    `CPA_ASSERT(a_rsp_source, $rose(rsp.valid) |-> $past(cmd.load_result), "spurious response")
    // sequencer commands are mutually exclusive
    `CPA_ASSERT(a_cmd_onehot, $onehot0(cmd), "overlapping datapath commands")

endmodule

// File: verif/tb_cidr_prefix_allowlist_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cidr_prefix_allowlist_core
// Self-checking bench for the IPv4/IPv6 CIDR allow-list core. A queue-fed
// driver sends insert and query transactions with random gaps. Each accepted
// request runs through a shadow copy of both prefix tables. A monitor with
// random back-pressure compares every response, field by field, in order.
// ----------------------------------------------------------------------------
module tb_cidr_prefix_allowlist_core;
    import cpa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;     // well past the longest query scan
    localparam int RANDOM_ITEMS = 1400;   // tables capped one short of full
    localparam int TAIL_ITEMS = 180;      // after both tables are full

    typedef struct packed {
        logic        cmd;
        logic        is_v6;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [7:0]  plen;
    } acl_request_t;

    typedef struct packed {
        logic       allowed;
        logic [1:0] status;
    } acl_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cpa_req_if req_if ();
    cpa_rsp_if rsp_if ();

    cidr_prefix_allowlist_core #(
        .V4_ENTRIES(V4_ENTRIES_DEF),
        .V6_ENTRIES(V6_ENTRIES_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow prefix tables. Updated only when the DUT accepts a request, so
    // they always track what the hardware holds at that point.
    // ------------------------------------------------------------------------
    logic [31:0]  acl4_net [V4_ENTRIES_DEF];
    logic [7:0]   acl4_len [V4_ENTRIES_DEF];
    int           acl4_fill = 0;
    logic [127:0] acl6_net [V6_ENTRIES_DEF];
    logic [7:0]   acl6_len [V6_ENTRIES_DEF];
    int           acl6_fill = 0;

    acl_request_t pending [$];      // requests waiting for the driver
    acl_verdict_t verdicts_due [$]; // responses owed by the DUT, oldest first

    // Stimulus-side record of the good inserts, used to aim queries at
    // stored networks. Filled when a request is queued, not when accepted.
    logic [31:0]  seed4_addr [$];
    int           seed4_len [$];
    logic [127:0] seed6_addr [$];
    int           seed6_len [$];

    int cycle_count = 0;
    int mismatches = 0;
    int n_insert = 0;
    int n_bad = 0;
    int n_full = 0;
    int n_query = 0;
    int n_allowed = 0;
    int n_checked = 0;

    // driver / monitor state
    int           send_gap = 0;
    int           hold_off = 0;
    int           sent_count = 0;
    bit           send_quiet = 1'b0;
    bit           recv_quiet = 1'b0;
    acl_request_t sent_req;
    acl_request_t next_req;
    acl_verdict_t got;

    function automatic logic [31:0] net_mask4(input int p);
        return (p == 0) ? 32'h0 : (~32'h0 << (V4_BITS - p));
    endfunction

    function automatic logic [127:0] net_mask6(input int p);
        return (p == 0) ? 128'h0 : ({V6_BITS{1'b1}} << (V6_BITS - p));
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // Idle length: none with zero_pct odds, else mostly short, a few long; none at all in a quiet stretch.
    function automatic int pause_len(input bit quiet, input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < zero_pct)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Apply one accepted request to the shadow tables and return the response
    // it must produce. Bad prefix wins over table full.
    function automatic acl_verdict_t judge_request(input acl_request_t r);
        acl_verdict_t v;
        logic [127:0] a6;
        v.allowed = 1'b0;
        v.status = ST_OK;
        a6 = {r.hi, r.lo};
        if (r.cmd == CMD_INSERT)
        begin
            n_insert++;
            if (r.is_v6)
            begin
                if (r.plen > V6_BITS)
                    v.status = ST_BAD_PREFIX;
                else if (acl6_fill >= V6_ENTRIES_DEF)
                    v.status = ST_FULL;
                else
                begin
                    acl6_net[acl6_fill] = a6 & net_mask6(r.plen);
                    acl6_len[acl6_fill] = r.plen;
                    acl6_fill++;
                end
            end
            else
            begin
                if (r.plen > V4_BITS)
                    v.status = ST_BAD_PREFIX;
                else if (acl4_fill >= V4_ENTRIES_DEF)
                    v.status = ST_FULL;
                else
                begin
                    acl4_net[acl4_fill] = r.lo[31:0] & net_mask4(r.plen);
                    acl4_len[acl4_fill] = r.plen;
                    acl4_fill++;
                end
            end
            if (v.status == ST_BAD_PREFIX)
                n_bad++;
            if (v.status == ST_FULL)
                n_full++;
        end
        else
        begin
            n_query++;
            // empty lists mean no filtering at all
            if (acl4_fill == 0 && acl6_fill == 0)
                v.allowed = 1'b1;
            else if (r.is_v6)
            begin
                for (int i = 0; i < acl6_fill; i++)
                    if ((a6 & net_mask6(acl6_len[i])) == acl6_net[i])
                        v.allowed = 1'b1;
            end
            else
            begin
                for (int i = 0; i < acl4_fill; i++)
                    if ((r.lo[31:0] & net_mask4(acl4_len[i])) == acl4_net[i])
                        v.allowed = 1'b1;
            end
            if (v.allowed)
                n_allowed++;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic queue_insert(input logic v6, input logic [127:0] addr,
                                input int len);
        acl_request_t r;
        r.cmd = CMD_INSERT;
        r.is_v6 = v6;
        {r.hi, r.lo} = addr;
        r.plen = len[7:0];
        pending = {pending, r};
        if (v6 && len <= V6_BITS && seed6_addr.size() < V6_ENTRIES_DEF)
        begin
            seed6_addr = {seed6_addr, addr};
            seed6_len = {seed6_len, len};
        end
        if (!v6 && len <= V4_BITS && seed4_addr.size() < V4_ENTRIES_DEF)
        begin
            seed4_addr = {seed4_addr, addr[31:0]};
            seed4_len = {seed4_len, len};
        end
    endtask

    // the prefix length is don't-care for a query; keep it random so it toggles
    task automatic queue_query(input logic v6, input logic [127:0] addr);
        acl_request_t r;
        r.cmd = CMD_QUERY;
        r.is_v6 = v6;
        {r.hi, r.lo} = addr;
        r.plen = 8'($urandom_range(0, 255));
        pending = {pending, r};
    endtask

    // Query inside a stored network with random host bits. A near miss flips
    // one network bit, which usually lands outside every entry.
    task automatic queue_probe(input logic v6, input bit near_miss);
        logic [127:0] a;
        logic [127:0] m6;
        logic [31:0]  m4;
        int k;
        int p;
        a = rand128();
        if (v6 && seed6_addr.size() != 0)
        begin
            k = $urandom_range(0, seed6_addr.size() - 1);
            p = seed6_len[k];
            m6 = net_mask6(p);
            a = (seed6_addr[k] & m6) | (a & ~m6);
            if (near_miss && p != 0)
                a[V6_BITS - $urandom_range(1, p)] ^= 1'b1;
        end
        else if (!v6 && seed4_addr.size() != 0)
        begin
            k = $urandom_range(0, seed4_addr.size() - 1);
            p = seed4_len[k];
            m4 = net_mask4(p);
            a[31:0] = (seed4_addr[k] & m4) | (a[31:0] & ~m4);
            if (near_miss && p != 0)
                a[V4_BITS - $urandom_range(1, p)] ^= 1'b1;
        end
        queue_query(v6, a);
    endtask

    // With keep_slot set, good inserts stop one entry short of a full table
    // so the zero-length prefix can still go in later.
    task automatic queue_random(input int insert_pct, input bit keep_slot);
        logic v6;
        int max_len;
        int limit;
        int stored;
        int q;
        v6 = 1'($urandom_range(0, 1));
        max_len = v6 ? V6_BITS : V4_BITS;
        limit = v6 ? V6_ENTRIES_DEF : V4_ENTRIES_DEF;
        stored = v6 ? seed6_addr.size() : seed4_addr.size();
        if ($urandom_range(0, 99) < insert_pct)
        begin
            if ((keep_slot && stored >= limit - 1) || $urandom_range(0, 3) == 0)
                queue_insert(v6, rand128(), $urandom_range(max_len + 1, 255));
            else
                queue_insert(v6, rand128(), $urandom_range(keep_slot ? 1 : 0, max_len));
        end
        else
        begin
            q = $urandom_range(0, 9);
            if (q < 6)
                queue_probe(v6, 1'b0);
            else if (q < 8)
                queue_probe(v6, 1'b1);
            else
                queue_query(v6, rand128());
        end
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || req_if.valid || verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: pops the pending queue, holds each transaction until
    // accepted, then idles for a random gap. Accepted requests feed the
    // shadow tables right at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.cmd <= CMD_INSERT;
            req_if.is_v6 <= 1'b0;
            req_if.address_high <= 64'h0;
            req_if.address_low <= 64'h0;
            req_if.plen <= 8'h0;
            send_gap <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                sent_req.cmd = req_if.cmd;
                sent_req.is_v6 = req_if.is_v6;
                sent_req.hi = req_if.address_high;
                sent_req.lo = req_if.address_low;
                sent_req.plen = req_if.plen;
                verdicts_due = {verdicts_due, judge_request(sent_req)};
                sent_count++;
                // switch between back-to-back and gappy stretches
                if (sent_count % 64 == 0)
                    send_quiet = ($urandom_range(0, 3) == 0);
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    req_if.valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    next_req = pending.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.cmd <= next_req.cmd;
                    req_if.is_v6 <= next_req.is_v6;
                    req_if.address_high <= next_req.hi;
                    req_if.address_low <= next_req.lo;
                    req_if.plen <= next_req.plen;
                    send_gap <= pause_len(send_quiet, 50);
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor: random ready stalls, in-order compare per field.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_off <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_checked++;
                if (n_checked % 50 == 0)
                    recv_quiet = ($urandom_range(0, 3) == 0);
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected response allowed=%0b status=%0d",
                             $time, rsp_if.allowed, rsp_if.status);
                end
                else
                begin
                    got = verdicts_due.pop_front();
                    if (rsp_if.allowed !== got.allowed)
                    begin
                        mismatches++;
                        $display("%0t: allowed mismatch: expected %0b, actual %0b",
                                 $time, got.allowed, rsp_if.allowed);
                    end
                    if (rsp_if.status !== got.status)
                    begin
                        mismatches++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, got.status, rsp_if.status);
                    end
                end
            end
            if (hold_off != 0)
            begin
                hold_off <= hold_off - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                hold_off <= pause_len(recv_quiet, 80);
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("cidr_prefix_allowlist_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        req_if.valid = 1'b0;
        req_if.cmd = CMD_INSERT;
        req_if.is_v6 = 1'b0;
        req_if.address_high = 64'h0;
        req_if.address_low = 64'h0;
        req_if.plen = 8'h0;
        rsp_if.ready = 1'b0;

        // Directed: empty lists allow everything, bad lengths leave them empty
        queue_query(1'b0, rand128());
        queue_query(1'b1, rand128());
        queue_insert(1'b0, rand128(), 33);
        queue_insert(1'b0, rand128(), 255);
        queue_insert(1'b1, rand128(), 129);
        queue_query(1'b0, rand128());
        // v4 host route; upper address bits must be ignored
        queue_insert(1'b0, {128{1'b1}}, 32);
        queue_query(1'b1, {128{1'b1}});              // v6 list still empty
        queue_query(1'b0, {64'h0, 64'h0000_0000_FFFF_FFFF});
        queue_query(1'b0, {64'h0, 64'h0000_0000_FFFF_FFFE});
        // /24 with host bits set, then the same entry again
        queue_insert(1'b0, {64'h0, 64'h0000_0000_0A0B_0CFF}, 24);
        queue_insert(1'b0, {64'h0, 64'h0000_0000_0A0B_0CFF}, 24);
        queue_query(1'b0, {64'h0, 64'hFFFF_FFFF_0A0B_0C01});
        queue_query(1'b0, {64'h0, 64'h0000_0000_0A0B_0D01});
        // v6 entries around the 64-bit half boundary
        queue_insert(1'b1, {128{1'b1}}, 48);
        queue_query(1'b1, {64'hFFFF_FFFF_FFFF_0000, 64'h0});
        queue_query(1'b1, {64'hFFFF_FFFE_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
        queue_insert(1'b1, {64'h0, 64'h1}, 128);
        queue_query(1'b1, {64'h0, 64'h1});
        queue_query(1'b1, {64'h0, 64'h0});
        queue_insert(1'b1, {64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF}, 64);
        queue_query(1'b1, {64'h0123_4567_89AB_CDEF, 64'h0});
        queue_insert(1'b1, {64'hFEDC_BA98_7654_3210, 64'h0}, 65);
        queue_query(1'b1, {64'hFEDC_BA98_7654_3210, 64'h8000_0000_0000_0000});
        queue_query(1'b1, {64'hFEDC_BA98_7654_3210, 64'h7FFF_FFFF_FFFF_FFFF});

        // Random: mostly queries aimed at stored networks
        for (int i = 0; i < RANDOM_ITEMS; i++)
            queue_random(10, 1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // hold the test sequence until the DUT has answered everything
        wait_idle();

        // Top up both lists, then the zero-length prefix takes the last slot
        while (seed4_addr.size() < V4_ENTRIES_DEF - 1)
            queue_insert(1'b0, rand128(), $urandom_range(1, V4_BITS));
        while (seed6_addr.size() < V6_ENTRIES_DEF - 1)
            queue_insert(1'b1, rand128(), $urandom_range(1, V6_BITS));
        queue_insert(1'b0, rand128(), 0);
        queue_insert(1'b1, rand128(), 0);
        queue_query(1'b0, rand128());
        queue_query(1'b1, rand128());
        // full lists: a bad length is reported ahead of table full
        queue_insert(1'b0, rand128(), 40);
        queue_insert(1'b0, rand128(), 16);
        queue_insert(1'b1, rand128(), 255);
        queue_insert(1'b1, rand128(), 128);
        queue_insert(1'b1, rand128(), 0);

        for (int i = 0; i < TAIL_ITEMS; i++)
            queue_random(40, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d responses never arrived", $time, verdicts_due.size());
        end

        $display("Run covered %0d inserts (%0d bad length, %0d table full),",
                 n_insert, n_bad, n_full);
        $display("%0d queries (%0d allowed), %0d responses compared, %0d cycles",
                 n_query, n_allowed, n_checked, cycle_count);
        if (mismatches == 0)
            $display("cidr_prefix_allowlist_core verification clean");
        else
            $display("cidr_prefix_allowlist_core verification failed");
        $finish;
    end

endmodule
